### src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/jse_pkg.sv
package jse_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned RUN_MAX = 6;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned LIM_W   = 31;
    localparam int unsigned OP_W    = 3;

    localparam logic [OP_W-1:0] OP_OPEN  = 3'd0;
    localparam logic [OP_W-1:0] OP_BYTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd2;
    localparam logic [OP_W-1:0] OP_NULL  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_LOWER_A_M10 = 8'h57; // 'a' - 10
    localparam logic [BYTE_W-1:0] CTRL_BOUND = 8'h20;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 31'h7FFF_FFFF;

    // Escaped run of one input transaction; byte 0 goes out first.
    typedef struct packed {
        logic [RUN_MAX-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]               len;
        logic                           clr;
    } t_run;

    // Strobes from the run stage to the byte budget.
    typedef struct packed {
        logic count;
        logic clear;
    } t_bud_ctl;

    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_digit = CH_ZERO + {4'd0, nib};
        end else begin
            hex_digit = CH_LOWER_A_M10 + {4'd0, nib};
        end
    endfunction

endpackage

### src/jse_expand.sv
module jse_expand import jse_pkg::*; (
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    output t_run              o_run
);

    always_comb begin
        o_run = '0;
        unique case (i_opcode)
            OP_OPEN, OP_CLOSE: begin
                o_run.bytes[0] = CH_QUOTE;
                o_run.len      = 3'd1;
            end
            OP_NULL: begin
                o_run.bytes[0] = 8'h6E; // n
                o_run.bytes[1] = 8'h75; // u
                o_run.bytes[2] = 8'h6C; // l
                o_run.bytes[3] = 8'h6C; // l
                o_run.len      = 3'd4;
            end
            OP_CLEAR: begin
                o_run.clr = 1'b1;
            end
            OP_BYTE: begin
                priority if (i_data_byte == CH_QUOTE || i_data_byte == CH_BSLASH) begin
                    o_run.bytes[0] = CH_BSLASH;
                    o_run.bytes[1] = i_data_byte;
                    o_run.len      = 3'd2;
                end else if (i_data_byte < CTRL_BOUND) begin
                    o_run.bytes[0] = CH_BSLASH;
                    o_run.len      = 3'd2;
                    unique case (i_data_byte)
                        8'h08: o_run.bytes[1] = 8'h62; // b
                        8'h09: o_run.bytes[1] = 8'h74; // t
                        8'h0A: o_run.bytes[1] = 8'h6E; // n
                        8'h0C: o_run.bytes[1] = 8'h66; // f
                        8'h0D: o_run.bytes[1] = 8'h72; // r
                        default: begin
                            o_run.bytes[1] = 8'h75; // u
                            o_run.bytes[2] = CH_ZERO;
                            o_run.bytes[3] = CH_ZERO;
                            o_run.bytes[4] = hex_digit(i_data_byte[7:4]);
                            o_run.bytes[5] = hex_digit(i_data_byte[3:0]);
                            o_run.len      = 3'd6;
                        end
                    endcase
                end else begin
                    o_run.bytes[0] = i_data_byte;
                    o_run.len      = 3'd1;
                end
            end
            default: begin
                // unused opcodes: empty run, no effect
                o_run = '0;
            end
        endcase
    end

endmodule

### src/jse_budget.sv
module jse_budget import jse_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bud_ctl         i_ctl,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_data,
    output logic             o_flag_next,
    output logic             o_flag
);

    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] n_used;
    logic             r_flag;
    logic [LIM_W-1:0] r_limit;

    // saturating increment, flag tested after the byte is counted
    assign n_used      = (r_used == {CNT_W{1'b1}}) ? r_used : r_used + 32'd1;
    assign o_flag_next = r_flag | (n_used > {1'b0, r_limit});
    assign o_flag      = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_flag  <= 1'b0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_ctl.clear) begin
                r_used <= '0;
                r_flag <= 1'b0;
            end else if (i_ctl.count) begin
                r_used <= n_used;
                r_flag <= o_flag_next;
            end
        end
    end

endmodule

### src/json_string_escaper_with_budget_unit.sv
// Path: an accepted transaction enters the run register, and its first byte passes through
// the output register to o_out_valid. Throughput: one input transaction per cycle when each
// yields one byte and the output does not stall; a transaction that yields more bytes holds
// the input while the single run register drains one byte a cycle, as the output allows.
// Clear and unused opcodes emit nothing.
// Reset (synchronous, active low): empties both stages, zeroes count and flag, limit to max.
`include "assert_macros.svh"

module json_string_escaper_with_budget_unit import jse_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [BYTE_W-1:0] i_data_byte,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_last_of_run,
    output logic              o_over_limit,
    // configuration
    input  logic              i_cfg_we,
    input  logic [LIM_W-1:0]  i_cfg_data
);

    // Expand the incoming transaction into its escaped run.
    t_run run_in;

    jse_expand u_expand (
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .o_run       (run_in)
    );

    // Run stage: holds the run of one transaction and the index of the next byte.
    logic             r_a_valid;
    t_run             r_a_run;
    logic [LEN_W-1:0] r_a_idx;

    // Output stage: one byte waiting for the consumer.
    logic              r_b_valid;
    logic [BYTE_W-1:0] r_b_byte;
    logic              r_b_last;
    logic              r_b_over;

    logic     in_fire;
    logic     a_move;      // a byte moves from run stage to output stage
    logic     a_idx_last;  // current index is the last byte of the run
    logic     a_done;      // run stage frees up at this edge
    logic     a_empty_run; // run stage holds a clear or an ignored opcode
    t_bud_ctl bud_ctl;
    logic     flag_next;
    logic     flag_q;

    assign in_fire     = i_in_valid && o_in_ready;
    assign a_empty_run = r_a_valid && (r_a_run.len == '0);
    assign a_idx_last  = (LEN_W'(r_a_idx + 3'd1) == r_a_run.len);
    // Advance a byte when the output register is free or being drained.
    assign a_move      = r_a_valid && (r_a_run.len != '0) && (!r_b_valid || i_out_ready);
    assign a_done      = a_empty_run || (a_move && a_idx_last);
    // Take a new transaction as soon as the run stage empties this cycle.
    assign o_in_ready  = !r_a_valid || a_done;

    assign bud_ctl.count = a_move;
    assign bud_ctl.clear = a_empty_run && r_a_run.clr;

    jse_budget u_budget (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (bud_ctl),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_flag_next (flag_next),
        .o_flag      (flag_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_idx   <= '0;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
                r_a_idx   <= '0;
            end else if (a_done) begin
                r_a_valid <= 1'b0;
            end else if (a_move) begin
                r_a_idx   <= LEN_W'(r_a_idx + 3'd1);
            end
        end
    end

    // payload of the run stage needs no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_run <= run_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_byte <= r_a_run.bytes[r_a_idx];
            r_b_last <= a_idx_last;
            r_b_over <= flag_next;
        end
    end

    assign o_out_valid   = r_b_valid;
    assign o_out_byte    = r_b_byte;
    assign o_last_of_run = r_b_last;
    assign o_over_limit  = r_b_over;

    // Never overwrite a byte the consumer has not taken.
    `ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, r_b_valid && !i_out_ready, !a_move,
        "byte moved into a stalled output register")
    // The byte index stays inside the run.
    `ASSERT_IMPL(a_idx_in_run, i_clk, i_rst_n, r_a_valid && (r_a_run.len != '0),
        r_a_idx < r_a_run.len, "run index past end of run")
    // The overflow flag is sticky until a clear.
    `ASSERT_NEXT(a_flag_sticky, i_clk, i_rst_n, flag_q && !bud_ctl.clear, flag_q,
        "overflow flag dropped without clear")
    // The run stage cannot be counting and clearing at once.
    `ASSERT_IMPL(a_count_xor_clear, i_clk, i_rst_n, bud_ctl.clear, !bud_ctl.count,
        "count and clear in the same cycle")

endmodule
